### rtl/core/weighted_spectral_level_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted spectral level tracker
// Shorthand for the clocked properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SPECTRAL_LEVEL_TRACKER_ASSERT_SVH
`define WEIGHTED_SPECTRAL_LEVEL_TRACKER_ASSERT_SVH

// Next-cycle implication that is suspended while reset is held.
`define WST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define WST_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/wst_pkg.sv
// ----------------------------------------------------------------------------
// wst_pkg
// Types and constants shared by the level tracker modules.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int BINS      = 1024;
  localparam int TABLES    = 5;
  localparam int LVL_W     = 24;
  localparam int CNT_W     = $clog2(BINS + 1);
  localparam int IDX_W     = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int ADDR_W    = $clog2(TABLES * BINS);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [LVL_W-1:0] LEVEL_MAX = {LVL_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_WLOAD = 2'd1,
    CMD_NLOAD = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_DATA,
    K_WLOAD,
    K_NLOAD,
    K_CLEAR
  } kind_t;

  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_HF_COEF  = 3'd1;
  localparam logic [2:0] CFG_LFS_COEF = 3'd2;
  localparam logic [2:0] CFG_LFF_COEF = 3'd3;
  localparam logic [2:0] CFG_DECAY    = 3'd4;

  localparam logic [1:0] MODE_HF = 2'd1;
  localparam logic [1:0] MODE_LF = 2'd2;

  localparam logic [2:0] T_HFS = 3'd0;
  localparam logic [2:0] T_HFF = 3'd1;
  localparam logic [2:0] T_LFS = 3'd2;
  localparam logic [2:0] T_LFF = 3'd3;
  localparam logic [2:0] T_TRN = 3'd4;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        tsel;
    logic [9:0]        bidx;
    logic [31:0]       lval;
    logic [LVL_W-1:0]  stage;
    logic [LVL_W-1:0]  skew;
    logic              last;
  } qitem_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_ROOT0,
    S_SQRT,
    S_NORM,
    S_LVL,
    S_DISP,
    S_P1,
    S_P2,
    S_TR1,
    S_TR2,
    S_NEXT,
    S_EMIT
  } bstate_t;

endpackage

### rtl/core/weighted_spectral_level_tracker.sv
// ----------------------------------------------------------------------------
// weighted_spectral_level_tracker
// Weighted RMS levels of five spectral bands with smoothing and peak hold.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Contents
//  input   | push / full         | command, table, bin index, load value, feeds
//  result  | pop / empty         | eight Q8.16 levels, one item per frame end
//  config  | cfg_we              | cfg_index selects one of five registers
//
// A data bin takes 5 passes (RD, MUL1, MUL2, ACC) through the shared weight
// memory read port and the multiply-accumulate; loads and clears are done as
// they leave the queue. A frame end adds per table a bit-pair square root
// plus norm and smoother multiplies. A four-item queue keeps accepting items
// while the sequencer works. Reset is synchronous and clears the queue,
// sums, smoothers and held levels; the weight memory and the norms hold
// nothing until loaded. A result that is not popped stalls the sequencer at
// frame end only.
// ----------------------------------------------------------------------------
module weighted_spectral_level_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_table_select,
  input  logic [9:0]  in_bin_index,
  input  logic [31:0] in_load_value,
  input  logic [23:0] in_stage_magnitude,
  input  logic [23:0] in_skew_magnitude,
  input  logic        in_last_bin,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] out_level_hf_sliding,
  output logic [23:0] out_level_hf_sliding_smoothed,
  output logic [23:0] out_level_hf_fixed,
  output logic [23:0] out_level_lf_sliding,
  output logic [23:0] out_level_lf_sliding_smoothed,
  output logic [23:0] out_level_lf_fixed,
  output logic [23:0] out_level_lf_fixed_smoothed,
  output logic [23:0] out_transient_peak,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wst_pkg::*;

  qhead_t                 q_head;
  logic                   q_pop;
  logic [7:0][LVL_W-1:0]  out_lv;

  // The front end only classifies and queues; all frame state lives in the back end.
  wst_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_command         (in_command),
    .in_table_select    (in_table_select),
    .in_bin_index       (in_bin_index),
    .in_load_value      (in_load_value),
    .in_stage_magnitude (in_stage_magnitude),
    .in_skew_magnitude  (in_skew_magnitude),
    .in_last_bin        (in_last_bin),
    .q_head             (q_head),
    .q_pop              (q_pop)
  );

  wst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_lv    (out_lv)
  );

  // Result fields in their documented order.
  assign out_level_hf_sliding          = out_lv[0];
  assign out_level_hf_sliding_smoothed = out_lv[1];
  assign out_level_hf_fixed            = out_lv[2];
  assign out_level_lf_sliding          = out_lv[3];
  assign out_level_lf_sliding_smoothed = out_lv[4];
  assign out_level_lf_fixed            = out_lv[5];
  assign out_level_lf_fixed_smoothed   = out_lv[6];
  assign out_transient_peak            = out_lv[7];

endmodule

### rtl/core/wst_front.sv
// ----------------------------------------------------------------------------
// wst_front
// Accepts items, classifies the command and queues them for the back end.
// ----------------------------------------------------------------------------
module wst_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             in_command,
  input  logic [2:0]             in_table_select,
  input  logic [9:0]             in_bin_index,
  input  logic [31:0]            in_load_value,
  input  logic [23:0]            in_stage_magnitude,
  input  logic [23:0]            in_skew_magnitude,
  input  logic                   in_last_bin,
  output wst_pkg::qhead_t        q_head,
  input  logic                   q_pop
);
  import wst_pkg::*;

  qitem_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  qitem_t              cls;
  logic                do_push, do_pop;

  always_comb begin
    cls.tsel  = in_table_select;
    cls.bidx  = in_bin_index;
    cls.lval  = in_load_value;
    cls.stage = in_stage_magnitude;
    cls.skew  = in_skew_magnitude;
    cls.last  = in_last_bin;
    unique case (cmd_t'(in_command))
      CMD_DATA:  cls.kind = K_DATA;
      CMD_WLOAD: cls.kind = (32'(in_table_select) < 32'(TABLES) &&
                             32'(in_bin_index) < 32'(BINS)) ? K_WLOAD : K_NOP;
      CMD_NLOAD: cls.kind = (32'(in_table_select) < 32'(TABLES)) ? K_NLOAD : K_NOP;
      CMD_CLEAR: cls.kind = K_CLEAR;
      default:   cls.kind = K_NOP;
    endcase
  end

  assign full         = (count_r == (QPTR_W+1)'(QDEPTH));
  assign do_push      = push && !full;
  assign do_pop       = q_pop && (count_r != '0);
  assign q_head.valid = (count_r != '0);
  assign q_head.item  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

### rtl/core/wst_back.sv
// ----------------------------------------------------------------------------
// wst_back
// Sequencer that accumulates weighted squares and computes frame levels.
// ----------------------------------------------------------------------------
module wst_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  wst_pkg::qhead_t               q_head,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [7:0][wst_pkg::LVL_W-1:0] out_lv
);
  import wst_pkg::*;

  bstate_t state_r, state_nxt;

  logic [1:0]  mode_r;
  logic [15:0] hf_c_r, lfs_c_r, lff_c_r, dec_c_r;

  logic [15:0]       wmem [TABLES * BINS];
  logic [15:0]       wrd_r;
  logic [31:0]       norm_r [TABLES];
  logic [63:0]       sum_r [TABLES];
  logic [CNT_W-1:0]  cnt_r;
  logic [LVL_W-1:0]  smo_r [6];
  logic [LVL_W-1:0]  prev_r, hold_r;
  logic [LVL_W-1:0]  held_r [8];

  qitem_t            cur_r;
  logic [2:0]        t_r;
  logic [LVL_W-1:0]  v_r;
  logic [47:0]       sq_r;
  logic [63:0]       rem_r, root_r, bit_r;
  logic [63:0]       prod_r;
  logic [LVL_W-1:0]  lvl_r, px_r;
  logic [40:0]       mp_r;
  logic              ph_r;
  logic              out_valid_r;
  logic [7:0][LVL_W-1:0] out_lv_r;

  logic [ADDR_W-1:0] raddr, waddr;
  logic [63:0]       trial;
  logic [2:0]        first_t, next_t;
  logic              has_next;
  logic [1:0]        pair;
  logic [2:0]        sidx;
  logic [15:0]       coef;
  logic [LVL_W-1:0]  px;
  logic [41:0]       pole_sum;
  logic [47:0]       lvl_p;
  logic [LVL_W-1:0]  rise, dec;
  logic              take;

  assign take  = (state_r == S_IDLE) && q_head.valid;
  assign q_pop = take;
  assign empty = !out_valid_r;
  assign out_lv = out_lv_r;

  assign raddr = ADDR_W'(t_r) * ADDR_W'(BINS) + ADDR_W'(cnt_r[IDX_W-1:0]);
  assign waddr = ADDR_W'(q_head.item.tsel) * ADDR_W'(BINS) + ADDR_W'(q_head.item.bidx);
  assign trial = root_r + bit_r;

  // Table order for the frame end follows the mode.
  always_comb begin
    first_t  = (mode_r == MODE_LF) ? T_LFS : T_HFS;
    has_next = (mode_r != MODE_HF) && (mode_r != MODE_LF) && (t_r != T_TRN);
    next_t   = t_r + 3'd1;
  end

  always_comb begin
    case (t_r)
      T_LFS:   begin pair = 2'd1; coef = lfs_c_r; end
      T_LFF:   begin pair = 2'd2; coef = lff_c_r; end
      default: begin pair = 2'd0; coef = hf_c_r; end
    endcase
    sidx     = {pair, 1'b0} + {2'b0, ph_r};
    px       = ph_r ? px_r : lvl_r;
    pole_sum = 42'(mp_r) + 42'(17'h10000 - {1'b0, coef}) * 42'(px) + 42'd32768;
    lvl_p    = 48'((prod_r + 64'd32768) >> 16);
    rise     = (lvl_r > prev_r) ? lvl_r - prev_r : '0;
    dec      = mp_r[39:16];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && q_head.item.kind == K_DATA) begin
          if (cnt_r < CNT_W'(BINS)) state_nxt = S_RD;
          else if (q_head.item.last) state_nxt = S_ROOT0;
        end
      end
      S_RD:    state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_ACC;
      S_ACC: begin
        if (t_r != T_TRN) state_nxt = S_RD;
        else if (cur_r.last) state_nxt = S_ROOT0;
        else state_nxt = S_IDLE;
      end
      S_ROOT0: state_nxt = S_SQRT;
      S_SQRT:  state_nxt = (bit_r[63:2] == '0) ? S_NORM : S_SQRT;
      S_NORM:  state_nxt = S_LVL;
      S_LVL:   state_nxt = S_DISP;
      S_DISP: begin
        if (t_r == T_HFF) state_nxt = S_NEXT;
        else if (t_r == T_TRN) state_nxt = S_TR1;
        else state_nxt = S_P1;
      end
      S_P1:    state_nxt = S_P2;
      S_P2:    state_nxt = ph_r ? S_NEXT : S_P1;
      S_TR1:   state_nxt = S_TR2;
      S_TR2:   state_nxt = S_NEXT;
      S_NEXT:  state_nxt = has_next ? S_ROOT0 : S_EMIT;
      S_EMIT:  state_nxt = (!out_valid_r || pop) ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (take && q_head.item.kind == K_WLOAD) begin
      wmem[waddr] <= q_head.item.lval[15:0];
    end
    wrd_r <= wmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (take && q_head.item.kind == K_NLOAD) begin
      norm_r[q_head.item.tsel] <= q_head.item.lval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      hf_c_r  <= '0;
      lfs_c_r <= '0;
      lff_c_r <= '0;
      dec_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode_r  <= cfg_data[1:0];
        CFG_HF_COEF:  hf_c_r  <= cfg_data;
        CFG_LFS_COEF: lfs_c_r <= cfg_data;
        CFG_LFF_COEF: lff_c_r <= cfg_data;
        CFG_DECAY:    dec_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cur_r <= q_head.item;
        t_r   <= (cnt_r < CNT_W'(BINS)) ? T_HFS : first_t;
      end
      S_MUL1:  v_r  <= LVL_W'((40'(wrd_r) * 40'((t_r == T_TRN) ? cur_r.skew : cur_r.stage)
                               + 40'd32768) >> 16);
      S_MUL2:  sq_r <= 48'(v_r) * 48'(v_r);
      S_ACC:   if (t_r != T_TRN) t_r <= t_r + 3'd1; else t_r <= first_t;
      S_ROOT0: begin
        rem_r  <= sum_r[t_r];
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_NORM:  prod_r <= 64'(root_r[31:0]) * 64'(norm_r[t_r]);
      S_LVL:   lvl_r  <= (lvl_p > 48'(LEVEL_MAX)) ? LEVEL_MAX : lvl_p[LVL_W-1:0];
      S_DISP:  ph_r   <= 1'b0;
      S_P1:    mp_r   <= 41'(coef) * 41'(smo_r[sidx]);
      S_P2: begin
        px_r <= pole_sum[16 +: LVL_W];
        ph_r <= 1'b1;
      end
      S_TR1:   mp_r   <= 41'(hold_r) * 41'(dec_c_r);
      S_NEXT:  t_r    <= next_t;
      default: ;
    endcase
  end

  // Frame state, held levels and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && q_head.item.kind == K_CLEAR)) begin
      for (int i = 0; i < TABLES; i++) sum_r[i] <= '0;
      for (int i = 0; i < 6; i++) smo_r[i] <= '0;
      for (int i = 0; i < 8; i++) held_r[i] <= '0;
      cnt_r  <= '0;
      prev_r <= '0;
      hold_r <= '0;
    end else begin
      case (state_r)
        S_ACC: begin
          sum_r[t_r] <= sum_r[t_r] + 64'(sq_r);
          if (t_r == T_TRN) cnt_r <= cnt_r + 1'b1;
        end
        S_DISP: begin
          case (t_r)
            T_HFS:   held_r[0] <= lvl_r;
            T_HFF:   held_r[2] <= lvl_r;
            T_LFS:   held_r[3] <= lvl_r;
            T_LFF:   held_r[5] <= lvl_r;
            default: ;
          endcase
        end
        S_P2: begin
          smo_r[sidx] <= pole_sum[16 +: LVL_W];
          if (ph_r) begin
            case (t_r)
              T_LFS:   held_r[4] <= pole_sum[16 +: LVL_W];
              T_LFF:   held_r[6] <= pole_sum[16 +: LVL_W];
              default: held_r[1] <= pole_sum[16 +: LVL_W];
            endcase
          end
        end
        S_TR2: begin
          prev_r    <= lvl_r;
          hold_r    <= (rise > dec) ? rise : dec;
          held_r[7] <= (rise > dec) ? rise : dec;
        end
        S_EMIT: begin
          if (!out_valid_r || pop) begin
            for (int i = 0; i < TABLES; i++) sum_r[i] <= '0;
            cnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && (!out_valid_r || pop)) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && (!out_valid_r || pop)) begin
      for (int i = 0; i < 8; i++) out_lv_r[i] <= held_r[i];
    end
  end

endmodule

### rtl/core/wst_checker.sv
// ----------------------------------------------------------------------------
// wst_checker
// Port-level checks of the level tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_spectral_level_tracker_assert.svh"

module wst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [23:0] out_level_hf_sliding,
  input logic [23:0] out_transient_peak
);

  // Reset leaves no result waiting and room in the queue.
  `WST_ASSERT_RST(a_reset_empty, !rst_n, empty, "result present after reset")
  `WST_ASSERT_RST(a_reset_room, !rst_n, !full, "queue full after reset")
  // A waiting result is held until it is popped.
  `WST_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_level_hf_sliding) && $stable(out_transient_peak), "result changed while waiting")

endmodule

bind weighted_spectral_level_tracker wst_checker u_wst_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .full                 (full),
  .empty                (empty),
  .pop                  (pop),
  .out_level_hf_sliding (out_level_hf_sliding),
  .out_transient_peak   (out_transient_peak)
);

### tb/weighted_spectral_level_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level tracker checker
// Watches both channels and the register port of the level tracker, works
// out the eight held levels for every frame end, and compares them with the
// items that leave the block.
// ----------------------------------------------------------------------------
module wst_level_checker
  import wst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_table_select,
  input  logic [9:0]  in_bin_index,
  input  logic [31:0] in_load_value,
  input  logic [23:0] in_stage_magnitude,
  input  logic [23:0] in_skew_magnitude,
  input  logic        in_last_bin,
  input  logic        empty,
  input  logic        pop,
  input  logic [23:0] out_level_hf_sliding,
  input  logic [23:0] out_level_hf_sliding_smoothed,
  input  logic [23:0] out_level_hf_fixed,
  input  logic [23:0] out_level_lf_sliding,
  input  logic [23:0] out_level_lf_sliding_smoothed,
  input  logic [23:0] out_level_lf_fixed,
  input  logic [23:0] out_level_lf_fixed_smoothed,
  input  logic [23:0] out_transient_peak,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  logic [15:0]            weight_mem [TABLES*BINS];
  logic [31:0]            norm_reg [TABLES];
  logic [63:0]            band_sum [TABLES];
  int unsigned            bin_pos;
  logic [LVL_W-1:0]       pole_st [6];
  logic [LVL_W-1:0]       prev_trn;
  logic [LVL_W-1:0]       peak_hold;
  logic [7:0][LVL_W-1:0]  held;
  logic [15:0]            reg_file [5];
  logic [7:0][LVL_W-1:0]  levels_due [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] clip(input logic [63:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v[LVL_W-1:0];
  endfunction

  function automatic logic [LVL_W-1:0] band_level(input int t);
    logic [63:0] root;
    root = isqrt(band_sum[t]);
    return clip((root * norm_reg[t] + 64'd32768) >> 16);
  endfunction

  function automatic logic [LVL_W-1:0] pole(input logic [15:0] c, input logic [LVL_W-1:0] s,
                                            input logic [LVL_W-1:0] x);
    logic [63:0] c64;
    c64 = c;
    return clip((c64 * s + (64'd65536 - c64) * x + 64'd32768) >> 16);
  endfunction

  // Two cascaded one-pole stages; the second stage is the smoothed level.
  function automatic logic [LVL_W-1:0] smooth_pair(input int p, input logic [15:0] c,
                                                   input logic [LVL_W-1:0] x);
    pole_st[2*p]   = pole(c, pole_st[2*p], x);
    pole_st[2*p+1] = pole(c, pole_st[2*p+1], pole_st[2*p]);
    return pole_st[2*p+1];
  endfunction

  function automatic void clear_frame();
    for (int t = 0; t < TABLES; t++) band_sum[t] = '0;
    bin_pos = 0;
  endfunction

  function automatic void clear_levels();
    clear_frame();
    for (int i = 0; i < 6; i++) pole_st[i] = '0;
    prev_trn = '0;
    peak_hold = '0;
    held = '0;
  endfunction

  function automatic void frame_end();
    logic [LVL_W-1:0] tl;
    logic [LVL_W-1:0] rise;
    logic [LVL_W-1:0] dec;
    logic [63:0]      prod;
    if (reg_file[CFG_MODE][1:0] == MODE_HF) begin
      held[0] = band_level(T_HFS);
      held[1] = smooth_pair(0, reg_file[CFG_HF_COEF], held[0]);
    end else if (reg_file[CFG_MODE][1:0] == MODE_LF) begin
      held[3] = band_level(T_LFS);
      held[4] = smooth_pair(1, reg_file[CFG_LFS_COEF], held[3]);
    end else begin
      held[0] = band_level(T_HFS);
      held[1] = smooth_pair(0, reg_file[CFG_HF_COEF], held[0]);
      held[2] = band_level(T_HFF);
      held[3] = band_level(T_LFS);
      held[4] = smooth_pair(1, reg_file[CFG_LFS_COEF], held[3]);
      held[5] = band_level(T_LFF);
      held[6] = smooth_pair(2, reg_file[CFG_LFF_COEF], held[5]);
      tl = band_level(T_TRN);
      rise = (tl > prev_trn) ? tl - prev_trn : '0;
      prev_trn = tl;
      prod = (64'(peak_hold) * reg_file[CFG_DECAY]) >> 16;
      dec = prod[LVL_W-1:0];
      peak_hold = (rise > dec) ? rise : dec;
      held[7] = peak_hold;
    end
    clear_frame();
    levels_due.push_back(held);
  endfunction

  function automatic void take_item();
    logic [63:0] v;
    logic [63:0] m;
    case (in_command)
      CMD_WLOAD: begin
        if (in_table_select < TABLES && in_bin_index < BINS)
          weight_mem[in_table_select*BINS + in_bin_index] = in_load_value[15:0];
      end
      CMD_NLOAD: begin
        if (in_table_select < TABLES) norm_reg[in_table_select] = in_load_value;
      end
      CMD_CLEAR: clear_levels();
      default: begin
        if (bin_pos < BINS) begin
          for (int t = 0; t < TABLES; t++) begin
            m = (t == T_TRN) ? in_skew_magnitude : in_stage_magnitude;
            v = (64'(weight_mem[t*BINS + bin_pos]) * m + 64'd32768) >> 16;
            band_sum[t] = band_sum[t] + v * v;
          end
          bin_pos++;
        end
        if (in_last_bin) frame_end();
      end
    endcase
  endfunction

  function automatic string level_name(input int i);
    case (i)
      0: return "level_hf_sliding";
      1: return "level_hf_sliding_smoothed";
      2: return "level_hf_fixed";
      3: return "level_lf_sliding";
      4: return "level_lf_sliding_smoothed";
      5: return "level_lf_fixed";
      6: return "level_lf_fixed_smoothed";
      default: return "transient_peak";
    endcase
  endfunction

  always @(posedge clk) begin
    logic [7:0][LVL_W-1:0] seen;
    logic [7:0][LVL_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) reg_file[i] = '0;
      clear_levels();
      levels_due.delete();
    end else begin
      if (cfg_we && cfg_index < 5) reg_file[cfg_index] = cfg_data;
      if (pop && !empty) begin
        seen = {out_transient_peak, out_level_lf_fixed_smoothed, out_level_lf_fixed,
                out_level_lf_sliding_smoothed, out_level_lf_sliding, out_level_hf_fixed,
                out_level_hf_sliding_smoothed, out_level_hf_sliding};
        if (levels_due.size() == 0) begin
          $error("result item with no frame end waiting");
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          for (int i = 0; i < 8; i++)
            if (seen[i] !== want[i]) begin
              $error("%s: expected %h, got %h", level_name(i), want[i], seen[i]);
              mismatches++;
            end
        end
      end
      if (push && !full) take_item();
    end
    pending = levels_due.size();
  end

endmodule

### tb/weighted_spectral_level_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level tracker testbench
// Loads weights and norms, plays directed and random frames through the
// tracker under several register settings and idling patterns, and lets the
// checker compare every result item.
// ----------------------------------------------------------------------------
module weighted_spectral_level_tracker_tb;
  import wst_pkg::*;

  // Mode zero is the full update; the unused code three behaves the same way.
  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  // Frames in the random part use only the first SHORT_BINS bins, which are loaded
  // up front, so no frame ever reads an unwritten weight.
  localparam int SHORT_BINS  = 16;
  // Quiet time before a register write: a full queue of data bins plus a
  // full-mode frame end, with margin.
  localparam int SETTLE      = 600;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = CMD_DATA;
  logic [2:0]  in_table_select = '0;
  logic [9:0]  in_bin_index = '0;
  logic [31:0] in_load_value = '0;
  logic [23:0] in_stage_magnitude = '0;
  logic [23:0] in_skew_magnitude = '0;
  logic        in_last_bin = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [23:0] out_level_hf_sliding;
  logic [23:0] out_level_hf_sliding_smoothed;
  logic [23:0] out_level_hf_fixed;
  logic [23:0] out_level_lf_sliding;
  logic [23:0] out_level_lf_sliding_smoothed;
  logic [23:0] out_level_lf_fixed;
  logic [23:0] out_level_lf_fixed_smoothed;
  logic [23:0] out_transient_peak;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  weighted_spectral_level_tracker dut (.*);

  wst_level_checker checker_i (.*, .pending(outstanding));

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver pops at random; the chance of a gap changes by phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one item, idling first at the current rate, and returns once the
  // item has been taken. Push stays high so back-to-back items need no gap.
  task automatic send_item(input cmd_t cmd, input logic [2:0] tsel, input logic [9:0] bidx,
                           input logic [31:0] lval, input logic [23:0] stage,
                           input logic [23:0] skew, input logic last);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_command <= cmd;
    in_table_select <= tsel;
    in_bin_index <= bidx;
    in_load_value <= lval;
    in_stage_magnitude <= stage;
    in_skew_magnitude <= skew;
    in_last_bin <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Loads and clears carry random junk in the fields they do not use.
  task automatic load_weight(input logic [2:0] tsel, input logic [9:0] bidx,
                             input logic [31:0] w);
    send_item(CMD_WLOAD, tsel, bidx, w, 24'($urandom), 24'($urandom), 1'($urandom));
  endtask

  task automatic load_norm(input logic [2:0] tsel, input logic [31:0] n);
    send_item(CMD_NLOAD, tsel, 10'($urandom), n, 24'($urandom), 24'($urandom),
              1'($urandom));
  endtask

  task automatic data_bin(input logic [23:0] stage, input logic [23:0] skew,
                          input logic last);
    send_item(CMD_DATA, 3'($urandom), 10'($urandom), $urandom, stage, skew, last);
  endtask

  function automatic logic [23:0] magnitude();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return 24'($urandom);
  endfunction

  // Norms either push the levels into saturation or keep them near unity.
  function automatic logic [31:0] norm_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h0002_0000);
  endfunction

  // Registers change only once the block has drained and gone quiet.
  task automatic set_config(input logic [1:0] mode, input logic [15:0] hf,
                            input logic [15:0] lfs, input logic [15:0] lff,
                            input logic [15:0] decay);
    logic [15:0] vals [5];
    vals = '{16'(mode), hf, lfs, lff, decay};
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic short_frame(input int len);
    for (int i = 0; i < len; i++) data_bin(magnitude(), magnitude(), i == len - 1);
  endtask

  // Mostly well-formed frames over the loaded bins, with weight and norm
  // reloads, ignored loads and the odd clear mixed in.
  task automatic random_stretch(input int n);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 80) begin
        len = $urandom_range(1, SHORT_BINS);
        short_frame(len);
        sent += len;
      end else begin
        if (r < 88) load_weight(3'($urandom_range(T_TRN)), 10'($urandom), $urandom);
        else if (r < 94) load_norm(3'($urandom_range(T_TRN)), norm_value());
        else if (r < 97) load_weight(3'($urandom_range(5, 7)), 10'($urandom), $urandom);
        else send_item(CMD_CLEAR, 3'($urandom), 10'($urandom), $urandom, 24'($urandom),
                       24'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [1:0] modes [6];
    modes = '{MODE_FULL, MODE_HF, MODE_LF, MODE_ALIAS, MODE_FULL, MODE_LF};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 10;
    recv_idle = 84;
    set_config(MODE_FULL, 16'h8000, 16'hC000, 16'h4000, 16'hF000);
    for (int t = 0; t <= T_TRN; t++) begin
      load_norm(3'(t), 32'h0001_0000);
      for (int b = 0; b < SHORT_BINS; b++) load_weight(3'(t), 10'(b), $urandom);
    end

    // Directed part: full-scale weights and feeds, a saturating norm, loads
    // that must be ignored, a last mark on a load and on a clear, a silent
    // frame and a single-bin frame after a clear.
    for (int t = 0; t <= T_TRN; t++) load_weight(3'(t), 10'd0, 32'hFFFF_FFFF);
    load_norm(T_HFS, 32'hFFFF_FFFF);
    load_weight(3'd7, 10'h3FF, 32'h0000_0000);
    load_norm(3'd5, 32'h0000_0000);
    send_item(CMD_WLOAD, T_TRN, 10'd1, 32'hFFFF_0000, '1, '1, 1'b1);
    data_bin('1, '1, 1'b1);
    data_bin('1, '0, 1'b1);
    data_bin('0, '0, 1'b0);
    data_bin('0, '0, 1'b1);
    data_bin('1, '1, 1'b1);
    send_item(CMD_CLEAR, '1, '1, '1, '1, '1, 1'b1);
    data_bin('1, '1, 1'b1);
    data_bin('0, '1, 1'b0);
    data_bin('1, '0, 1'b1);
    load_norm(T_HFS, 32'h0001_0000);

    // Random part: six stretches, each under its own register setting, with
    // the idling pattern moving on every two stretches.
    for (int k = 0; k < 6; k++) begin
      send_idle = (k < 2) ? 10 : (k < 4) ? 84 : 0;
      recv_idle = (k < 2) ? 84 : (k < 4) ? 10 : 0;
      if (k == 0) set_config(modes[k], '0, '0, '0, '0);
      else if (k == 1) set_config(modes[k], '1, '1, '1, '1);
      else set_config(modes[k], 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
      random_stretch(290);
    end

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
